FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the codec RTL; they compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define LEBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define LEBC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LEBC_ASSERT(lbl, prop, msg)
`define LEBC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/lebc_pkg.sv
// Shared types, constants and helper functions of the LEB128 varint codec.
`timescale 1ns / 1ps
`default_nettype none

package lebc_pkg;

  // Datapath sizes.
  localparam int unsigned DataW     = 64;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned MaxGroups = (ValueBits + GroupBits - 1) / GroupBits;
  localparam int unsigned GrpW      = $clog2(MaxGroups + 1);
  localparam int unsigned ShW       = $clog2(MaxGroups * GroupBits + 1);
  localparam int unsigned IdxW      = $clog2(DataW);

  // Job queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Mask of the bits that belong to a value.
  localparam logic [DataW-1:0] VMask = {DataW{1'b1}} >> (DataW - ValueBits);

  typedef enum logic [1:0] {
    ModeDecU = 2'd0,
    ModeDecS = 2'd1,
    ModeEncU = 2'd2,
    ModeEncS = 2'd3
  } mode_e;

  typedef enum logic {
    KindByte  = 1'b0,
    KindValue = 1'b1
  } kind_e;

  typedef enum logic {
    BkIdle = 1'b0,
    BkEnc  = 1'b1
  } back_state_e;

  // One job handed from the front to the back.
  typedef struct packed {
    logic             is_enc;
    logic             sgn;
    logic             ovf;
    logic [GrpW-1:0]  grp;
    logic [DataW-1:0] value;
  } lebc_job_t;

  // Sign-extend a value of ValueBits bits to the full data width.
  function automatic logic [DataW-1:0] widen_signed(input logic [DataW-1:0] v);
    logic [DataW-1:0] r;
    r = v & VMask;
    if (r[ValueBits-1]) begin
      r = r | ~VMask;
    end
    return r;
  endfunction

  // Bit position of a group: seven bits per group.
  function automatic logic [ShW-1:0] group_shift(input logic [GrpW-1:0] g);
    return ShW'(g) * ShW'(GroupBits);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lebc_front.sv
// Front end: accepts items, accumulates decode bytes and issues jobs to the queue.
`timescale 1ns / 1ps
`default_nettype none

module lebc_front
  import lebc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic             q_full_i,
  input  wire logic [1:0]       mode_i,
  input  wire logic [7:0]       byte_in_i,
  input  wire logic [DataW-1:0] value_in_i,
  output      logic             job_push_o,
  output      lebc_job_t        job_o
);

  logic [DataW-1:0] part_q, part_d;
  logic [GrpW-1:0]  grp_q, grp_d;
  logic [GrpW-1:0]  grp_eff, grp_nxt;
  logic [DataW-1:0] part_nxt;
  logic             accept, is_enc, is_sgn, more, fin;
  mode_e            mode;

  // Classify the item.
  assign mode   = mode_e'(mode_i);
  assign accept = push_i && !q_full_i;
  assign is_enc = (mode == ModeEncU) || (mode == ModeEncS);
  assign is_sgn = (mode == ModeDecS) || (mode == ModeEncS);
  assign more   = byte_in_i[7];

  // Place the byte's data group at the next position of the running value.
  always_comb begin
    grp_eff  = (grp_q >= GrpW'(MaxGroups)) ? '0 : grp_q;
    part_nxt = (part_q | (DataW'(byte_in_i[6:0]) << group_shift(grp_eff))) & VMask;
    grp_nxt  = grp_eff + GrpW'(1);
    fin      = !more || (grp_nxt >= GrpW'(MaxGroups));
  end

  // Decode state update.
  always_comb begin
    part_d = part_q;
    grp_d  = grp_q;
    if (accept && !is_enc) begin
      if (fin) begin
        part_d = '0;
        grp_d  = '0;
      end else begin
        part_d = part_nxt;
        grp_d  = grp_nxt;
      end
    end
  end

  // Job for the back end: a finished decode or a whole encode.
  always_comb begin
    job_push_o = accept && (is_enc || fin);
    job_o.is_enc = is_enc;
    job_o.sgn    = is_sgn;
    job_o.ovf    = !is_enc && more;
    job_o.grp    = is_enc ? '0 : grp_nxt;
    if (is_enc) begin
      job_o.value = is_sgn ? widen_signed(value_in_i) : (value_in_i & VMask);
    end else begin
      job_o.value = part_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      grp_q  <= '0;
    end else begin
      part_q <= part_d;
      grp_q  <= grp_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lebc_queue.sv
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lebc_queue
  import lebc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire lebc_job_t job_i,
  input  wire logic      pop_i,
  output      lebc_job_t head_o,
  output      logic      full_o,
  output      logic      empty_o
);

  lebc_job_t        slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  `LEBC_ASSERT_NEVER(a_push_full, push_i && full_o, "job pushed into a full queue")
  `LEBC_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "job popped from an empty queue")
  `LEBC_ASSERT(a_cnt_ptrs, QPtrW'(cnt_q) == (wr_ptr_q - rd_ptr_q), "level and pointers disagree")

endmodule

`default_nettype wire

FILE: hw/rtl/lebc_back.sv
// Back end: forms decoded values, emits encoded bytes and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lebc_back
  import lebc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lebc_job_t        head_i,
  input  wire logic             q_empty_i,
  output      logic             q_pop_o,
  input  wire logic             pop_i,
  output      logic             out_valid_o,
  output      logic             kind_o,
  output      logic [7:0]       byte_out_o,
  output      logic [DataW-1:0] value_out_o,
  output      logic             last_o,
  output      logic             overflow_o
);

  back_state_e      state_q, state_d;
  logic [DataW-1:0] work_v_q, work_v_d;
  logic             work_sgn_q, work_sgn_d;
  logic [GrpW-1:0]  cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic [DataW-1:0] value_q, value_d;
  logic             last_q, last_d;
  logic             ovf_q, ovf_d;

  logic             load, emit;
  logic [DataW-1:0] src_v, vn, dec_v;
  logic             src_sgn, done, fin, sign_bit;
  logic [GrpW-1:0]  src_cnt;
  logic [6:0]       grp_data;
  logic [ShW-1:0]   sh;

  // The result register can take a new result when empty or being drained.
  assign load = !out_valid_q || pop_i;

  // One encode step: take the low group and shift the rest down.
  always_comb begin
    src_v    = (state_q == BkEnc) ? work_v_q : head_i.value;
    src_sgn  = (state_q == BkEnc) ? work_sgn_q : head_i.sgn;
    src_cnt  = (state_q == BkEnc) ? cnt_q : '0;
    grp_data = src_v[6:0];
    vn       = {{GroupBits{src_v[DataW-1] & src_sgn}}, src_v[DataW-1:GroupBits]};
    if (src_sgn) begin
      done = ((vn == '0) && !grp_data[6]) || ((vn == '1) && grp_data[6]);
    end else begin
      done = (vn == '0);
    end
    fin = done || (src_cnt == GrpW'(MaxGroups - 1));
  end

  // Final decoded value: sign extension from the top decoded group.
  always_comb begin
    sh       = group_shift(head_i.grp);
    sign_bit = head_i.value[IdxW'(sh - ShW'(1))];
    dec_v    = head_i.value;
    if (head_i.sgn) begin
      if ((sh < ShW'(ValueBits)) && sign_bit) begin
        dec_v = dec_v | ({DataW{1'b1}} << sh);
      end
      dec_v = widen_signed(dec_v);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (load && !q_empty_i && head_i.is_enc && !fin) begin
          state_d = BkEnc;
        end
      end
      BkEnc: begin
        if (load && fin) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // Outputs of the state machine and datapath updates.
  always_comb begin
    q_pop_o     = load && (state_q == BkIdle) && !q_empty_i;
    emit        = q_pop_o || ((state_q == BkEnc) && load);
    work_v_d    = work_v_q;
    work_sgn_d  = work_sgn_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !pop_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    value_d     = value_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if ((state_q == BkIdle) && !head_i.is_enc) begin
        kind_d  = KindValue;
        byte_d  = '0;
        value_d = dec_v;
        last_d  = 1'b0;
        ovf_d   = head_i.ovf;
      end else begin
        kind_d     = KindByte;
        byte_d     = {!fin, grp_data};
        value_d    = '0;
        last_d     = fin;
        ovf_d      = 1'b0;
        work_v_d   = vn;
        work_sgn_d = src_sgn;
        cnt_d      = src_cnt + GrpW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_v_q   <= work_v_d;
    work_sgn_q <= work_sgn_d;
    kind_q     <= kind_d;
    byte_q     <= byte_d;
    value_q    <= value_d;
    last_q     <= last_d;
    ovf_q      <= ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign value_out_o = value_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_q;

  `LEBC_ASSERT(a_enc_cnt,
               (state_q == BkEnc) |-> ((cnt_q != '0) && (cnt_q < GrpW'(MaxGroups))),
               "encode byte count out of range")
  `LEBC_ASSERT(a_enc_limit,
               ((state_q == BkEnc) && load && (cnt_q == GrpW'(MaxGroups - 1)))
                 |=> (state_q == BkIdle),
               "encode ran past its byte limit")
  `LEBC_ASSERT(a_dec_fields,
               (out_valid_q && (kind_q == KindValue)) |-> (!last_q && (byte_q == '0)),
               "decode result carries byte fields")
  `LEBC_ASSERT(a_emit_fills, emit |=> out_valid_q, "emitted result was not captured")

endmodule

`default_nettype wire

FILE: hw/rtl/leb128_varint_codec.sv
// Top level of the 64-bit LEB128 varint encoder and decoder.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+-------------------------------------------
//  input    | push in, full out              | mode_i, byte_in_i, value_in_i
//  result   | empty out, pop in              | kind_o, byte_out_o, value_out_o, last_o,
//           |                                | overflow_o
//
// A decode byte is added to the running value as it is taken; a finished value goes through
// the job queue into the result register and waits in the queue while that register is occupied.
// An encode item occupies the back end until all of its output bytes (1 to 10) are out;
// the byte emitter shifts out one 7-bit group per cycle whenever the result register can load.
// A four-entry job queue lets input transfers continue while bytes drain.
// Reset clears the decode accumulator, the queue and the result register.
`timescale 1ns / 1ps
`default_nettype none

module leb128_varint_codec
  import lebc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output      logic             full,
  input  wire logic [1:0]       mode_i,
  input  wire logic [7:0]       byte_in_i,
  input  wire logic [DataW-1:0] value_in_i,
  output      logic             empty,
  input  wire logic             pop,
  output      logic             kind_o,
  output      logic [7:0]       byte_out_o,
  output      logic [DataW-1:0] value_out_o,
  output      logic             last_o,
  output      logic             overflow_o
);

  lebc_job_t job, head;
  logic      job_push, q_full, q_empty, q_pop, out_valid;

  lebc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .q_full_i   (q_full),
    .mode_i     (mode_i),
    .byte_in_i  (byte_in_i),
    .value_in_i (value_in_i),
    .job_push_o (job_push),
    .job_o      (job)
  );

  lebc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (q_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lebc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .kind_o      (kind_o),
    .byte_out_o  (byte_out_o),
    .value_out_o (value_out_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: tb/tb_leb128_varint_codec.sv
// Self-checking testbench for the LEB128 varint codec: directed and random encode/decode traffic.
`timescale 1ns / 1ps

module tb_leb128_varint_codec
  import lebc_pkg::*;
;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned CalmAfter = 260;
  localparam int unsigned HoldAfter = 60;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 30;

  // One result as it appears on the output ports.
  typedef struct {
    kind_e            kind;
    logic [7:0]       byte_val;
    logic [DataW-1:0] value;
    logic             last;
    logic             ovf;
  } codec_result_t;

  // Predicts the codec's results from each input transfer and checks the output transfers.
  class leb_scoreboard;
    codec_result_t    expected_q[$];
    logic [DataW-1:0] partial_value;
    int unsigned      group_count;
    int unsigned      num_accepted;
    int unsigned      num_errors;

    function new();
      partial_value = '0;
      group_count = 0;
      num_accepted = 0;
      num_errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Encode a value as 1 to 10 bytes, least significant group first.
    function void predict_encode(logic [DataW-1:0] value, bit sgn);
      logic [DataW-1:0] v;
      logic [6:0]       grp;
      bit               done;
      codec_result_t    r;
      v = value;
      for (int n = 0; n < MaxGroups; n++) begin
        grp = v[6:0];
        if (sgn) begin
          v = $signed(v) >>> GroupBits;
          done = (v == '0 && !grp[6]) || (v == '1 && grp[6]);
        end else begin
          v = v >> GroupBits;
          done = (v == '0);
        end
        r.kind = KindByte;
        r.value = '0;
        r.ovf = 1'b0;
        if (done || n == MaxGroups - 1) begin
          r.byte_val = {1'b0, grp};
          r.last = 1'b1;
          expected_q.push_back(r);
          break;
        end
        r.byte_val = {1'b1, grp};
        r.last = 1'b0;
        expected_q.push_back(r);
      end
    endfunction

    // Add one byte to the running decode; a final or over-long byte gives a value.
    function void predict_decode(logic [7:0] byte_val, bit sgn);
      int unsigned      g;
      int unsigned      shift;
      logic [DataW-1:0] v;
      logic [DataW-1:0] ones;
      codec_result_t    r;
      ones = '1;
      g = group_count;
      if (g >= MaxGroups) g = 0;
      shift = GroupBits * g;
      partial_value = partial_value | (DataW'(byte_val[6:0]) << shift);
      g++;
      if (byte_val[7] && g < MaxGroups) begin
        group_count = g;
        return;
      end
      v = partial_value;
      shift = GroupBits * g;
      if (sgn && shift < ValueBits && v[shift-1]) begin
        v = v | ~(ones >> (DataW - shift));
      end
      r.kind = KindValue;
      r.byte_val = '0;
      r.value = v;
      r.last = 1'b0;
      r.ovf = byte_val[7];
      expected_q.push_back(r);
      partial_value = '0;
      group_count = 0;
    endfunction

    function void note_input(mode_e mode, logic [7:0] byte_val, logic [DataW-1:0] value);
      num_accepted++;
      case (mode)
        ModeEncU: predict_encode(value, 1'b0);
        ModeEncS: predict_encode(value, 1'b1);
        ModeDecS: predict_decode(byte_val, 1'b1);
        default:  predict_decode(byte_val, 1'b0);
      endcase
    endfunction

    function void check_result(logic kind, logic [7:0] byte_val, logic [DataW-1:0] value,
                               logic last, logic ovf);
      codec_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %h value %h", $time, kind, byte_val,
                 value);
        num_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
        num_errors++;
      end
      if (byte_val !== e.byte_val) begin
        $display("%0t: byte_out expected %h actual %h", $time, e.byte_val, byte_val);
        num_errors++;
      end
      if (value !== e.value) begin
        $display("%0t: value_out expected %h actual %h", $time, e.value, value);
        num_errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, last);
        num_errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %0d actual %0d", $time, e.ovf, ovf);
        num_errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic [1:0]       mode_i;
  logic [7:0]       byte_in_i;
  logic [DataW-1:0] value_in_i;
  logic             empty;
  logic             pop;
  logic             kind_o;
  logic [7:0]       byte_out_o;
  logic [DataW-1:0] value_out_o;
  logic             last_o;
  logic             overflow_o;

  bit               calm;
  bit               quiet_in;
  leb_scoreboard    sb = new();

  leb128_varint_codec uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .byte_in_i   (byte_in_i),
    .value_in_i  (value_in_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .byte_out_o  (byte_out_o),
    .value_out_o (value_out_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(mode_e mode, logic [7:0] byte_val, logic [DataW-1:0] value);
    @(negedge clk);
    push <= 1'b1;
    mode_i <= mode;
    byte_in_i <= byte_val;
    value_in_i <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(mode, byte_val, value);
  endtask

  // At random, lower push for a burst of cycles, unless the run is calm or in a quiet stretch.
  task automatic maybe_gap();
    int unsigned n;
    if (calm || quiet_in || $urandom_range(0, 5) != 0) return;
    n = $urandom_range(1, 11);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_encode(bit sgn);
    int unsigned      w;
    logic [DataW-1:0] v;
    logic [DataW-1:0] ones;
    ones = '1;
    w = ($urandom_range(0, 3) == 0) ? DataW : $urandom_range(1, 21);
    v = rand64() & (ones >> (DataW - w));
    if (sgn && $urandom_range(0, 1)) v = ~v;
    send_item(sgn ? ModeEncS : ModeEncU, 8'($urandom), v);
  endtask

  // A decode run; cont_last keeps the continuation bit on the final byte too.
  task automatic send_decode_run(int unsigned len, bit cont_last);
    mode_e      m;
    logic [7:0] b;
    m = $urandom_range(0, 1) ? ModeDecS : ModeDecU;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      b[7] = (i != len - 1) || cont_last;
      if ($urandom_range(0, 7) == 0) m = (m == ModeDecU) ? ModeDecS : ModeDecU;
      send_item(m, b, rand64());
      maybe_gap();
    end
  endtask

  // Result side: random stalls, one long hold-off to fill the block, and steady draining once calm.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    stall_left = 0;
    hold_left = 0;
    held = 0;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.num_accepted >= HoldAfter) begin
        held = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Check every output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_result(kind_o, byte_out_o, value_out_o, last_o, overflow_o);
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned pick;
    int unsigned sent_before;
    push = 1'b0;
    mode_i = ModeDecU;
    byte_in_i = '0;
    value_in_i = '0;
    rst_n = 1'b0;
    calm = 0;
    quiet_in = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Encode extremes: zero, all ones, the most negative, minus one, sign boundary values.
    send_item(ModeEncU, 8'h00, 64'h0);
    send_item(ModeEncU, 8'hff, '1);
    send_item(ModeEncS, 8'h5a, 64'h8000_0000_0000_0000);
    send_item(ModeEncS, 8'ha5, '1);
    send_item(ModeEncS, 8'h00, 64'd63);
    send_item(ModeEncS, 8'h00, 64'd64);
    send_item(ModeEncS, 8'h00, 64'h7fff_ffff_ffff_ffff);
    // Single-byte decodes: zero unsigned, all data bits set read as signed.
    send_item(ModeDecU, 8'h00, '1);
    send_item(ModeDecS, 8'h7f, 64'h0);
    // Two-byte decode whose final byte is signed while the first was unsigned.
    send_item(ModeDecU, 8'h80, 64'h0);
    send_item(ModeDecS, 8'h40, 64'h0);
    // Over-long decode: ten bytes all with the continuation bit, modes mixed.
    for (int i = 0; i < MaxGroups; i++) begin
      send_item(mode_e'(i % 2), 8'hff, rand64());
    end
    // The decoder restarts after the over-long run.
    send_item(ModeDecU, 8'h01, 64'h0);

    // Random traffic, mostly well-formed decode runs and encodes.
    sent_before = sb.num_accepted;
    while (sb.num_accepted - sent_before < RandomItems) begin
      if (sb.num_accepted - sent_before >= CalmAfter) calm = 1;
      if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        send_encode(pick[0]);
        maybe_gap();
      end else if (pick < 16) begin
        send_decode_run(($urandom_range(0, 4) == 0) ? $urandom_range(5, MaxGroups)
                                                    : $urandom_range(1, 4), 1'b0);
      end else if (pick < 18) begin
        send_decode_run(MaxGroups, 1'b1);
      end else begin
        // Noise: random bytes with random continuation bits.
        send_decode_run($urandom_range(1, 6), $urandom_range(0, 1));
      end
    end
    // Close any unfinished decode so nothing is left in the accumulator.
    send_item(ModeDecU, 8'h00, 64'h0);
    @(negedge clk);
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.num_errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
